// File: rtl/fat_chain_allocator_top_assert.svh
// assertion macros for the chain allocator
// used by fat_chain_allocator_top; no other dependencies
`ifndef FAT_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define FCA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fca assertion failed");
// next-cycle implication, off during reset
`define FCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fca assertion failed");
`else
`define FCA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/fca_pkg.sv
// shared types and codes for the chain allocator
// no dependencies
package fca_pkg;

  // request kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_SCAN,
    S_LINK,
    S_ENDW,
    S_DONE
  } fca_state_t;

endpackage

// File: rtl/fat_chain_allocator_top.sv
// File allocation table chain allocator. After reset the block runs a clearing
// pass over every entry of both tables and accepts no transaction meanwhile.
// It then takes one request at a time. A release or unused kind goes from idle
// to the done state and on to the output register. An allocate takes a node
// from the bump counter while it has room, else runs the first-fit scan, one
// free mark read per cycle. An append first walks the chain to its tail (one
// next-pointer read per cycle), then makes two link writes, with the scan in
// between when the bump range is used up. A new request is taken while the
// previous result still waits in the output register.
// depends on fca_pkg, fca_ram and fat_chain_allocator_top_assert.svh
`include "fat_chain_allocator_top_assert.svh"

module fat_chain_allocator_top #(
  parameter int NODE_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [9:0] node,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] new_node,
  output logic [9:0] tail_node,
  output logic       tail_moved,
  output logic [1:0] status
);
  import fca_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int CW = IW + 1;
  localparam int HW = (CW > 10) ? CW : 10;
  localparam logic [CW-1:0] NodeCnt  = CW'(NODE_COUNT);
  localparam logic [CW-1:0] ScanLast = CW'(NODE_COUNT - 2);
  localparam logic [CW-1:0] ScanFirst = CW'(2);
  localparam logic [IW-1:0] BumpFull = IW'(NODE_COUNT - 1);

  // registers
  fca_state_t    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] bump, bump_next;
  logic [IW-1:0] alloc_idx, alloc_idx_next;
  logic          is_append, is_append_next;
  logic          head_in, head_in_next;
  logic [9:0]    r_new, r_new_next;
  logic [9:0]    r_tail, r_tail_next;
  logic          r_moved, r_moved_next;
  logic [1:0]    r_status, r_status_next;
  logic          out_valid_next;
  logic          load_out;

  // table ports
  logic          np_we;
  logic [IW-1:0] np_waddr, np_raddr;
  logic [CW-1:0] np_wdata, np_rdata;
  logic          fm_we;
  logic [IW-1:0] fm_waddr, fm_raddr;
  logic [0:0]    fm_wdata, fm_rdata;

  logic          node_in_table;
  logic [IW-1:0] node_idx;

  assign node_in_table = HW'(node) < HW'(NODE_COUNT);
  assign node_idx      = IW'(node);

  // next-pointer table
  fca_ram #(.WIDTH(CW), .DEPTH(NODE_COUNT)) u_next_ptr (
    .clk   (clk),
    .we    (np_we),
    .waddr (np_waddr),
    .wdata (np_wdata),
    .raddr (np_raddr),
    .rdata (np_rdata)
  );

  // free mark table
  fca_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_free_mark (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer: next state, table accesses, working registers
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cur_next       = cur;
    bump_next      = bump;
    alloc_idx_next = alloc_idx;
    is_append_next = is_append;
    head_in_next   = head_in;
    r_new_next     = r_new;
    r_tail_next    = r_tail;
    r_moved_next   = r_moved;
    r_status_next  = r_status;
    np_we          = 1'b0;
    np_waddr       = cur;
    np_wdata       = NodeCnt;
    np_raddr       = node_idx;
    fm_we          = 1'b0;
    fm_waddr       = alloc_idx;
    fm_wdata       = 1'b0;
    fm_raddr       = IW'(2);

    case (state)
      // sweep both tables to their reset contents
      S_CLEAR: begin
        np_we    = 1'b1;
        np_waddr = cnt[IW-1:0];
        np_wdata = NodeCnt;
        fm_we    = 1'b1;
        fm_waddr = cnt[IW-1:0];
        fm_wdata = (cnt >= ScanFirst) && (cnt <= ScanLast);
        cnt_next = cnt + CW'(1);
        if (cnt == NodeCnt - CW'(1)) begin
          state_next = S_IDLE;
        end
      end

      // take a request; the head read is issued here for appends
      S_IDLE: begin
        if (in_valid) begin
          r_new_next     = '0;
          r_tail_next    = '0;
          r_moved_next   = 1'b0;
          r_status_next  = STATUS_OK;
          is_append_next = 1'b0;
          head_in_next   = node_in_table;
          cur_next       = node_idx;
          cnt_next       = '0;
          case (kind)
            KIND_ALLOC: begin
              state_next = S_ALLOC;
            end
            KIND_APPEND: begin
              is_append_next = 1'b1;
              if (node_in_table) begin
                state_next = S_WALK;
              end else begin
                r_tail_next = node;
                state_next  = S_ALLOC;
              end
            end
            KIND_RELEASE: begin
              fm_we      = node_in_table;
              fm_waddr   = node_idx;
              fm_wdata   = 1'b1;
              state_next = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // follow the chain, one link per cycle
      S_WALK: begin
        if (np_rdata == NodeCnt) begin
          r_tail_next = 10'(cur);
          state_next  = S_ALLOC;
        end else if (cnt == NodeCnt) begin
          r_tail_next   = 10'(cur);
          r_status_next = STATUS_TOO_LONG;
          state_next    = S_DONE;
        end else begin
          cur_next     = np_rdata[IW-1:0];
          np_raddr     = np_rdata[IW-1:0];
          cnt_next     = cnt + CW'(1);
          r_moved_next = 1'b1;
        end
      end

      // bump allocation, or start the first-fit scan
      S_ALLOC: begin
        if ({1'b0, bump} < ScanLast) begin
          bump_next      = bump + IW'(1);
          alloc_idx_next = bump + IW'(1);
          fm_we          = 1'b1;
          fm_waddr       = bump + IW'(1);
          fm_wdata       = 1'b0;
          r_new_next     = 10'(bump + IW'(1));
          state_next     = is_append ? S_LINK : S_DONE;
        end else begin
          bump_next  = BumpFull;
          cnt_next   = ScanFirst;
          fm_raddr   = IW'(2);
          state_next = S_SCAN;
        end
      end

      // first-fit scan, one free mark per cycle
      S_SCAN: begin
        fm_raddr = IW'(cnt + CW'(1));
        if (fm_rdata[0]) begin
          alloc_idx_next = cnt[IW-1:0];
          fm_we          = 1'b1;
          fm_waddr       = cnt[IW-1:0];
          fm_wdata       = 1'b0;
          r_new_next     = 10'(cnt[IW-1:0]);
          state_next     = is_append ? S_LINK : S_DONE;
        end else if (cnt == ScanLast) begin
          r_status_next = STATUS_NO_FREE;
          state_next    = S_DONE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      // link the tail to the new node
      S_LINK: begin
        np_we      = head_in;
        np_waddr   = cur;
        np_wdata   = {1'b0, alloc_idx};
        state_next = S_ENDW;
      end

      // end the chain at the new node
      S_ENDW: begin
        np_we      = 1'b1;
        np_waddr   = alloc_idx;
        np_wdata   = NodeCnt;
        state_next = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      bump      <= IW'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      bump      <= bump_next;
      out_valid <= out_valid_next;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    alloc_idx <= alloc_idx_next;
    is_append <= is_append_next;
    head_in   <= head_in_next;
    r_new     <= r_new_next;
    r_tail    <= r_tail_next;
    r_moved   <= r_moved_next;
    r_status  <= r_status_next;
    if (load_out) begin
      new_node   <= r_new;
      tail_node  <= r_tail;
      tail_moved <= r_moved;
      status     <= r_status;
    end
  end

  // failed requests never report a node
  `FCA_ASSERT_IMPLY(a_fail_no_node, clk, rst, out_valid && (status != STATUS_OK), new_node == 10'd0)
  // an over-long chain has always moved off the head
  `FCA_ASSERT_IMPLY(a_long_moved, clk, rst, out_valid && (status == STATUS_TOO_LONG), tail_moved)
  // the walk never counts past the table size
  `FCA_ASSERT_IMPLY(a_walk_bound, clk, rst, state == S_WALK, cnt <= NodeCnt)
  // the scan stays inside the first-fit range
  `FCA_ASSERT_IMPLY(a_scan_bound, clk, rst, state == S_SCAN, (cnt >= ScanFirst) && (cnt <= ScanLast))
  // nothing is taken or shown during the clearing pass
  `FCA_ASSERT_NEXT(a_clear_quiet, clk, rst, state == S_CLEAR, !out_valid)

endmodule

// File: rtl/fca_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module fca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: tb/fat_chain_allocator_checker.sv
`timescale 1ns / 100ps
// scoreboard for the chain allocator: mirrors the next-pointer table, free marks
// and bump counter, predicts every result and compares it field by field
// depends on fca_pkg
module fat_chain_allocator_checker #(
  parameter int NODE_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] kind,
  input  logic [9:0] node,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [9:0] new_node,
  input  logic [9:0] tail_node,
  input  logic       tail_moved,
  input  logic [1:0] status,
  output int         mismatches,
  output int         outstanding
);
  import fca_pkg::*;

  localparam int FIRST_NODE = 2;
  localparam logic [10:0] END_MARK = 11'(NODE_COUNT);

  typedef struct packed {
    logic [9:0] new_node;
    logic [9:0] tail_node;
    logic       tail_moved;
    logic [1:0] status;
  } grant_t;

  // shadow copy of the allocator state
  logic [10:0] next_ptr [NODE_COUNT];
  bit          free_mark [NODE_COUNT];
  logic [10:0] bump_count;

  grant_t expected_grants [$];
  grant_t oldest_grant;
  int     error_count = 0;

  task automatic clear_tables();
    int i;
    for (i = 0; i < NODE_COUNT; i++) begin
      next_ptr[i] = END_MARK;
      free_mark[i] = (i >= FIRST_NODE && i < NODE_COUNT - 1);
    end
    bump_count = 11'd1;
  endtask

  // bump counter first, then lowest free node from the first usable index
  function automatic logic [9:0] claim_node();
    int i;
    logic [9:0] found;
    found = '0;
    if (int'(bump_count) + 1 < NODE_COUNT - 1) begin
      bump_count = bump_count + 11'd1;
      free_mark[bump_count] = 1'b0;
      found = bump_count[9:0];
    end else begin
      bump_count = 11'(NODE_COUNT - 1);
      for (i = FIRST_NODE; i < NODE_COUNT - 1 && found == '0; i++) begin
        if (free_mark[i]) begin
          free_mark[i] = 1'b0;
          found = 10'(i);
        end
      end
    end
    return found;
  endfunction

  // result of one request, updating the shadow state
  function automatic grant_t allocate_and_link(logic [1:0] op, logic [9:0] arg);
    grant_t g;
    logic [10:0] cur;
    int steps;
    bit walking;
    g = '0;
    case (op)
      KIND_ALLOC: begin
        g.new_node = claim_node();
        if (g.new_node == '0) g.status = STATUS_NO_FREE;
      end
      KIND_APPEND: begin
        cur = {1'b0, arg};
        steps = 0;
        walking = 1'b1;
        // follow the chain to its tail, giving up after a table's worth of links
        while (walking) begin
          if (cur >= NODE_COUNT || next_ptr[cur] == END_MARK) begin
            walking = 1'b0;
          end else if (steps >= NODE_COUNT) begin
            walking = 1'b0;
            g.status = STATUS_TOO_LONG;
          end else begin
            cur = next_ptr[cur];
            steps++;
            g.tail_moved = 1'b1;
          end
        end
        g.tail_node = cur[9:0];
        if (g.status != STATUS_TOO_LONG) begin
          g.new_node = claim_node();
          if (g.new_node == '0) begin
            g.status = STATUS_NO_FREE;
          end else begin
            if (cur < NODE_COUNT) next_ptr[cur] = {1'b0, g.new_node};
            next_ptr[g.new_node] = END_MARK;
          end
        end
      end
      KIND_RELEASE: begin
        if (arg < NODE_COUNT) free_mark[arg] = 1'b1;
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // predict on input transactions, check on output transactions
  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      expected_grants.delete();
    end else begin
      if (in_valid && in_ready) expected_grants.push_back(allocate_and_link(kind, node));
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result: new_node %0d tail_node %0d status %0d",
                 new_node, tail_node, status);
          error_count++;
        end else begin
          oldest_grant = expected_grants.pop_front();
          compare_field("new_node", oldest_grant.new_node, new_node);
          compare_field("tail_node", oldest_grant.tail_node, tail_node);
          compare_field("tail_moved", oldest_grant.tail_moved, tail_moved);
          compare_field("status", oldest_grant.status, status);
        end
      end
    end
    mismatches <= error_count;
    outstanding <= expected_grants.size();
  end

endmodule

// File: tb/fat_chain_allocator_top_test.sv
`timescale 1ns / 100ps
// top of the chain allocator testbench: clock, reset, request stimulus,
// result back-pressure and verdict; depends on fca_pkg, fat_chain_allocator_top
// and fat_chain_allocator_checker
module fat_chain_allocator_top_test;
  import fca_pkg::*;

  localparam int NODE_COUNT = 1024;
  localparam int FILL_ITEMS = 1100;
  localparam int MIX_ITEMS = 830;
  localparam int CALM_ITEMS = 200;
  localparam int HOLD_AFTER = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int HEAD_POOL = 8;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = KIND_ALLOC;
  logic [9:0] node = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [9:0] new_node;
  logic [9:0] tail_node;
  logic       tail_moved;
  logic [1:0] status;

  int mismatches;
  int outstanding;
  int sent = 0;
  int gap_odds = 0;
  int stall_odds = 0;
  int quiet_count = 0;
  int hold_count;
  bit calm = 1'b0;
  bit hold_done = 1'b0;
  logic [9:0] chain_heads [HEAD_POOL];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fat_chain_allocator_top #(
    .NODE_COUNT(NODE_COUNT)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .node      (node),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_node  (new_node),
    .tail_node (tail_node),
    .tail_moved(tail_moved),
    .status    (status)
  );

  fat_chain_allocator_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) grant_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .node       (node),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .new_node   (new_node),
    .tail_node  (tail_node),
    .tail_moved (tail_moved),
    .status     (status),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // one request transaction, with an optional idle burst ahead of it
  task automatic offer(input logic [1:0] op, input logic [9:0] arg);
    if (sent % 64 == 0) begin
      case ($urandom_range(2))
        0: begin gap_odds = 0; stall_odds = 0; end
        1: begin gap_odds = 15; stall_odds = 15; end
        default: begin gap_odds = 45; stall_odds = 45; end
      endcase
    end
    if (!calm && $urandom_range(99) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    node <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // append heads come half from a small pool so that some chains grow long
  task automatic random_request(input int alloc_pct, input int append_pct,
                                input int release_pct);
    int roll;
    logic [9:0] arg;
    roll = $urandom_range(99);
    arg = 10'($urandom_range(NODE_COUNT - 1));
    if (roll < alloc_pct) begin
      offer(KIND_ALLOC, arg);
    end else if (roll < alloc_pct + append_pct) begin
      if ($urandom_range(1)) arg = chain_heads[$urandom_range(HEAD_POOL - 1)];
      offer(KIND_APPEND, arg);
    end else if (roll < alloc_pct + append_pct + release_pct) begin
      offer(KIND_RELEASE, arg);
    end else begin
      offer(KIND_SPARE, arg);
    end
  endtask

  // result side: one long hold-off early on, then random stall bursts
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!hold_done && sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
      end else if (!calm && $urandom_range(99) < stall_odds) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < HEAD_POOL; i++) chain_heads[i] = 10'($urandom_range(NODE_COUNT - 1));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: bump allocations, chains off the edge nodes, releases, spare kind
    offer(KIND_ALLOC, 10'd0);
    offer(KIND_ALLOC, 10'd1023);
    offer(KIND_APPEND, 10'd0);
    offer(KIND_APPEND, 10'd0);
    offer(KIND_APPEND, 10'd1023);
    offer(KIND_APPEND, 10'd1);
    offer(KIND_APPEND, 10'd1023);
    offer(KIND_APPEND, 10'd2);
    offer(KIND_RELEASE, 10'd2);
    offer(KIND_RELEASE, 10'd0);
    offer(KIND_RELEASE, 10'd1023);
    offer(KIND_RELEASE, 10'd1);
    offer(KIND_SPARE, 10'd1023);
    offer(KIND_SPARE, 10'd0);
    offer(KIND_ALLOC, 10'd682);
    offer(KIND_APPEND, 10'd5);
    // released node still in the middle of a chain
    offer(KIND_RELEASE, 10'd5);
    offer(KIND_APPEND, 10'd0);
    offer(KIND_ALLOC, 10'd341);
    offer(KIND_APPEND, 10'd682);
    offer(KIND_RELEASE, 10'd341);
    offer(KIND_SPARE, 10'd682);

    // fill: use up the bump range and run into the no-free-node case
    for (i = 0; i < FILL_ITEMS; i++) random_request(70, 25, 3);

    // mixed traffic on a nearly full table, first-fit scans throughout
    for (i = 0; i < MIX_ITEMS; i++) begin
      if (i == MIX_ITEMS - CALM_ITEMS) calm = 1'b1;
      random_request(35, 25, 38);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
